@@ rtl/core/qmr_pkg.sv @@
// Shared types and constants of the quaternion multiply / rotate unit.
// Holds the request and result structs and the Hamilton product term tables.
// No dependencies.
`default_nettype none

package qmr_pkg;

    localparam int QMR_FRAC_BITS = 16;
    localparam int QMR_COMP_W    = 32;
    // One extra bit so that the negated most negative component is exact.
    localparam int QMR_OPND_W    = QMR_COMP_W + 1;
    localparam int QMR_PROD_W    = 2 * QMR_OPND_W;

    localparam logic [1:0] QMR_IDX_W = 2'd0;
    localparam logic [1:0] QMR_IDX_X = 2'd1;
    localparam logic [1:0] QMR_IDX_Y = 2'd2;
    localparam logic [1:0] QMR_IDX_Z = 2'd3;

    localparam logic QMR_ACT_MULTIPLY = 1'b0;
    localparam logic QMR_ACT_ROTATE   = 1'b1;

    typedef logic signed [QMR_COMP_W-1:0] comp_t;
    typedef logic signed [QMR_OPND_W-1:0] opnd_t;
    typedef comp_t [3:0] comp_quat_t;
    typedef opnd_t [3:0] opnd_quat_t;

    typedef struct packed {
        logic  action;
        comp_t a_w;
        comp_t a_x;
        comp_t a_y;
        comp_t a_z;
        comp_t b_w;
        comp_t b_x;
        comp_t b_y;
        comp_t b_z;
    } qmr_in_t;

    typedef struct packed {
        comp_t r_w;
        comp_t r_x;
        comp_t r_y;
        comp_t r_z;
    } qmr_out_t;

    // Sideband carried alongside each Hamilton product pass.
    typedef struct packed {
        logic       action;
        comp_quat_t quat;
    } qmr_side_t;

    // For result component k, term t is left[LEFT] * right[RIGHT], negated where NEG.
    localparam logic [1:0] QMR_HAM_LEFT [4][4] = '{
        '{QMR_IDX_W, QMR_IDX_X, QMR_IDX_Y, QMR_IDX_Z},
        '{QMR_IDX_W, QMR_IDX_X, QMR_IDX_Y, QMR_IDX_Z},
        '{QMR_IDX_W, QMR_IDX_X, QMR_IDX_Y, QMR_IDX_Z},
        '{QMR_IDX_W, QMR_IDX_X, QMR_IDX_Y, QMR_IDX_Z}
    };

    localparam logic [1:0] QMR_HAM_RIGHT [4][4] = '{
        '{QMR_IDX_W, QMR_IDX_X, QMR_IDX_Y, QMR_IDX_Z},
        '{QMR_IDX_X, QMR_IDX_W, QMR_IDX_Z, QMR_IDX_Y},
        '{QMR_IDX_Y, QMR_IDX_Z, QMR_IDX_W, QMR_IDX_X},
        '{QMR_IDX_Z, QMR_IDX_Y, QMR_IDX_X, QMR_IDX_W}
    };

    localparam logic QMR_HAM_NEG [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0}
    };

endpackage

`default_nettype wire

@@ rtl/core/quaternion_multiply_rotate.sv @@
// Top level of the fixed-point quaternion multiply / vector rotate unit.
// Two qmr_hamilton pipelines in series; depends on qmr_pkg and qmr_hamilton.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+----------------------------------------
//   cmd     | cmd_valid / cmd_ready | qmr_in_t: action, quaternions a and b
//   res     | res_valid / res_ready | qmr_out_t: r_w, r_x, r_y, r_z
//
// One request is taken every cycle while cmd_ready is high; each result passes through
// the product, term and sum stages of each of the two Hamilton product pipelines.
// Multiply results pass through the second pipeline unchanged to keep order.
// Reset clears only the stage valid bits. A stall on res holds each stage that
// is full and lets empty stages fill, so cmd_ready falls only when all are full.
`default_nettype none

module quaternion_multiply_rotate #(
    parameter int FRAC_BITS = qmr_pkg::QMR_FRAC_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire qmr_pkg::qmr_in_t cmd,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output qmr_pkg::qmr_out_t     res
);
    import qmr_pkg::*;

    localparam int SIDE_W = $bits(qmr_side_t);

    opnd_quat_t l1;
    opnd_quat_t r1;
    qmr_side_t  side1_in;
    logic [SIDE_W-1:0] side1_out;
    qmr_side_t  side1;
    comp_quat_t p1;
    logic       p1_valid;
    logic       p1_ready;

    opnd_quat_t l2;
    opnd_quat_t r2;
    qmr_side_t  side2_in;
    logic [SIDE_W-1:0] side2_out;
    qmr_side_t  side2;
    comp_quat_t p2;

    always_comb
    begin
        l1[QMR_IDX_W] = QMR_OPND_W'(cmd.a_w);
        l1[QMR_IDX_X] = QMR_OPND_W'(cmd.a_x);
        l1[QMR_IDX_Y] = QMR_OPND_W'(cmd.a_y);
        l1[QMR_IDX_Z] = QMR_OPND_W'(cmd.a_z);
        // For rotate the vector is the pure quaternion with a zero real part.
        r1[QMR_IDX_W] = (cmd.action == QMR_ACT_ROTATE) ? '0 : QMR_OPND_W'(cmd.b_w);
        r1[QMR_IDX_X] = QMR_OPND_W'(cmd.b_x);
        r1[QMR_IDX_Y] = QMR_OPND_W'(cmd.b_y);
        r1[QMR_IDX_Z] = QMR_OPND_W'(cmd.b_z);
        side1_in.action          = cmd.action;
        side1_in.quat[QMR_IDX_W] = cmd.a_w;
        side1_in.quat[QMR_IDX_X] = cmd.a_x;
        side1_in.quat[QMR_IDX_Y] = cmd.a_y;
        side1_in.quat[QMR_IDX_Z] = cmd.a_z;
    end

    qmr_hamilton #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_valid),
        .in_ready  (cmd_ready),
        .in_l      (l1),
        .in_r      (r1),
        .in_side   (side1_in),
        .out_valid (p1_valid),
        .out_ready (p1_ready),
        .out_q     (p1),
        .out_side  (side1_out)
    );

    assign side1 = qmr_side_t'(side1_out);

    // Second pass multiplies by conj(a); the extra operand bit holds -(-2^31) exactly.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            l2[i] = QMR_OPND_W'(p1[i]);
        end
        r2[QMR_IDX_W] = QMR_OPND_W'(side1.quat[QMR_IDX_W]);
        r2[QMR_IDX_X] = -QMR_OPND_W'(side1.quat[QMR_IDX_X]);
        r2[QMR_IDX_Y] = -QMR_OPND_W'(side1.quat[QMR_IDX_Y]);
        r2[QMR_IDX_Z] = -QMR_OPND_W'(side1.quat[QMR_IDX_Z]);
        side2_in.action = side1.action;
        side2_in.quat   = p1;
    end

    qmr_hamilton #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid),
        .in_ready  (p1_ready),
        .in_l      (l2),
        .in_r      (r2),
        .in_side   (side2_in),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_q     (p2),
        .out_side  (side2_out)
    );

    assign side2 = qmr_side_t'(side2_out);

    always_comb
    begin
        if (side2.action == QMR_ACT_ROTATE)
        begin
            res.r_w = '0;
            res.r_x = p2[QMR_IDX_X];
            res.r_y = p2[QMR_IDX_Y];
            res.r_z = p2[QMR_IDX_Z];
        end
        else
        begin
            res.r_w = side2.quat[QMR_IDX_W];
            res.r_x = side2.quat[QMR_IDX_X];
            res.r_y = side2.quat[QMR_IDX_Y];
            res.r_z = side2.quat[QMR_IDX_Z];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/qmr_hamilton.sv @@
// Three-stage pipelined fixed-point Hamilton product with rounding and saturation.
// Stages: sixteen products, rounded and signed terms, four-term sum with saturation.
// Depends on qmr_pkg.
`default_nettype none

module qmr_hamilton #(
    parameter int FRAC_BITS = qmr_pkg::QMR_FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire qmr_pkg::opnd_quat_t in_l,
    input  wire qmr_pkg::opnd_quat_t in_r,
    input  wire logic [SIDE_W-1:0]   in_side,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output qmr_pkg::comp_quat_t      out_q,
    output logic [SIDE_W-1:0]        out_side
);
    import qmr_pkg::*;

    localparam int TERM_W = QMR_PROD_W - FRAC_BITS;
    localparam int SUM_W  = TERM_W + 2;

    localparam logic signed [QMR_PROD_W-1:0] HALF =
        {{(QMR_PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-QMR_COMP_W+1){1'b0}}, {(QMR_COMP_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-QMR_COMP_W+1){1'b1}}, {(QMR_COMP_W-1){1'b0}}};
    localparam logic [QMR_COMP_W-1:0] COMP_MAX = {1'b0, {(QMR_COMP_W-1){1'b1}}};
    localparam logic [QMR_COMP_W-1:0] COMP_MIN = {1'b1, {(QMR_COMP_W-1){1'b0}}};

    logic                           s1_valid_reg;
    logic signed [QMR_PROD_W-1:0]   s1_prod_reg [4][4];
    logic signed [QMR_PROD_W-1:0]   s1_prod_next [4][4];
    logic [SIDE_W-1:0]              s1_side_reg;

    logic                           s2_valid_reg;
    logic signed [TERM_W-1:0]       s2_term_reg [4][4];
    logic signed [TERM_W-1:0]       s2_term_next [4][4];
    logic [SIDE_W-1:0]              s2_side_reg;

    logic                           s3_valid_reg;
    comp_quat_t                     s3_q_reg;
    comp_quat_t                     s3_q_next;
    logic [SIDE_W-1:0]              s3_side_reg;

    logic s1_ok;
    logic s2_ok;
    logic s3_ok;

    // A stage may load when it is empty or its contents move on this cycle.
    assign s3_ok    = !s3_valid_reg || out_ready;
    assign s2_ok    = !s2_valid_reg || s3_ok;
    assign s1_ok    = !s1_valid_reg || s2_ok;
    assign in_ready = s1_ok;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                s1_prod_next[k][t] = QMR_PROD_W'($signed(in_l[QMR_HAM_LEFT[k][t]]))
                                   * QMR_PROD_W'($signed(in_r[QMR_HAM_RIGHT[k][t]]));
            end
        end
    end

    // Round to nearest with ties upward: add half an LSB, then shift arithmetically.
    always_comb
    begin
        logic signed [QMR_PROD_W-1:0] rnd;
        logic signed [QMR_PROD_W-1:0] shifted;
        logic signed [TERM_W-1:0]     mag;
        rnd     = '0;
        shifted = '0;
        mag     = '0;
        for (int k = 0; k < 4; k++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                rnd     = s1_prod_reg[k][t] + HALF;
                shifted = rnd >>> FRAC_BITS;
                mag     = shifted[TERM_W-1:0];
                s2_term_next[k][t] = QMR_HAM_NEG[k][t] ? -mag : mag;
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < 4; k++)
        begin
            sum = SUM_W'(s2_term_reg[k][0]) + SUM_W'(s2_term_reg[k][1])
                + SUM_W'(s2_term_reg[k][2]) + SUM_W'(s2_term_reg[k][3]);
            priority if (sum > SAT_MAX)
                s3_q_next[k] = COMP_MAX;
            else if (sum < SAT_MIN)
                s3_q_next[k] = COMP_MIN;
            else
                s3_q_next[k] = sum[QMR_COMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ok)
                s1_valid_reg <= in_valid;
            if (s2_ok)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ok)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ok && in_valid)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_side_reg <= in_side;
        end
        if (s2_ok && s1_valid_reg)
        begin
            s2_term_reg <= s2_term_next;
            s2_side_reg <= s1_side_reg;
        end
        if (s3_ok && s2_valid_reg)
        begin
            s3_q_reg    <= s3_q_next;
            s3_side_reg <= s2_side_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_q     = s3_q_reg;
    assign out_side  = s3_side_reg;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the quaternion multiply / rotate unit: drives requests with random
// gaps and stalls, predicts each result in fixed point and compares every field.
// Depends on qmr_pkg and quaternion_multiply_rotate.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import qmr_pkg::*;

    localparam int SINK_HOLD_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT     = 4000;
    localparam int DRAIN_CYCLES       = 20;

    localparam comp_t Q_ONE  = 32'sh0001_0000;
    localparam comp_t Q_MAX  = 32'sh7FFF_FFFF;
    localparam comp_t Q_MIN  = 32'sh8000_0000;
    localparam comp_t Q_ZERO = 32'sh0000_0000;

    // Components held wide so that the negated most negative value stays exact.
    typedef struct {
        longint w;
        longint x;
        longint y;
        longint z;
    } wide_quat_t;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    qmr_in_t  cmd       = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    qmr_out_t res;

    int       send_gap_pct   = 0;
    int       sink_stall_pct = 0;
    bit       sink_hold_req  = 1'b0;
    int       mismatch_count = 0;
    int       results_seen   = 0;
    qmr_out_t pending_results[$];
    qmr_out_t next_result;

    quaternion_multiply_rotate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint rounded_term(longint p, longint q);
        longint prod;
        prod = p * q + (longint'(1) << (QMR_FRAC_BITS - 1));
        return prod >>> QMR_FRAC_BITS;
    endfunction

    function automatic longint clamp_comp(longint v);
        if (v > 64'sh0000_0000_7FFF_FFFF)
            return 64'sh0000_0000_7FFF_FFFF;
        if (v < -64'sh0000_0000_8000_0000)
            return -64'sh0000_0000_8000_0000;
        return v;
    endfunction

    function automatic wide_quat_t hamilton_product(wide_quat_t l, wide_quat_t r);
        wide_quat_t o;
        o.w = clamp_comp(rounded_term(l.w, r.w) - rounded_term(l.x, r.x)
                       - rounded_term(l.y, r.y) - rounded_term(l.z, r.z));
        o.x = clamp_comp(rounded_term(l.w, r.x) + rounded_term(l.x, r.w)
                       + rounded_term(l.y, r.z) - rounded_term(l.z, r.y));
        o.y = clamp_comp(rounded_term(l.w, r.y) - rounded_term(l.x, r.z)
                       + rounded_term(l.y, r.w) + rounded_term(l.z, r.x));
        o.z = clamp_comp(rounded_term(l.w, r.z) + rounded_term(l.x, r.y)
                       - rounded_term(l.y, r.x) + rounded_term(l.z, r.w));
        return o;
    endfunction

    function automatic qmr_out_t predict_quat_result(qmr_in_t req);
        wide_quat_t a;
        wide_quat_t b;
        wide_quat_t conj_a;
        wide_quat_t prod;
        qmr_out_t   o;
        a.w = longint'($signed(req.a_w));
        a.x = longint'($signed(req.a_x));
        a.y = longint'($signed(req.a_y));
        a.z = longint'($signed(req.a_z));
        b.w = longint'($signed(req.b_w));
        b.x = longint'($signed(req.b_x));
        b.y = longint'($signed(req.b_y));
        b.z = longint'($signed(req.b_z));
        if (req.action == QMR_ACT_MULTIPLY)
        begin
            prod = hamilton_product(a, b);
        end
        else
        begin
            b.w      = 0;
            conj_a.w = a.w;
            conj_a.x = -a.x;
            conj_a.y = -a.y;
            conj_a.z = -a.z;
            // The first product is saturated before the second pass.
            prod   = hamilton_product(hamilton_product(a, b), conj_a);
            prod.w = 0;
        end
        o.r_w = comp_t'(prod.w);
        o.r_x = comp_t'(prod.x);
        o.r_y = comp_t'(prod.y);
        o.r_z = comp_t'(prod.z);
        return o;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return comp_t'(int'($urandom_range(524288)) - 262144);
            3, 4, 5: return comp_t'(int'($urandom_range(33554432)) - 16777216);
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic qmr_in_t make_request(logic act, comp_t aw, comp_t ax, comp_t ay,
                                             comp_t az, comp_t bw, comp_t bx, comp_t by,
                                             comp_t bz);
        qmr_in_t r;
        r.action = act;
        r.a_w = aw;
        r.a_x = ax;
        r.a_y = ay;
        r.a_z = az;
        r.b_w = bw;
        r.b_x = bx;
        r.b_y = by;
        r.b_z = bz;
        return r;
    endfunction

    function automatic qmr_in_t rand_request(int rotate_pct);
        logic act;
        act = ($urandom_range(99) < rotate_pct) ? QMR_ACT_ROTATE : QMR_ACT_MULTIPLY;
        return make_request(act, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                            rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endfunction

    // Entered and left at a falling edge; valid stays high when no gap follows.
    task automatic send_request(input qmr_in_t item);
        int gap;
        gap = pick_gap(send_gap_pct);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        do
            @(posedge clk);
        while (!cmd_ready);
        pending_results.push_back(predict_quat_result(item));
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        send_request(make_request(QMR_ACT_MULTIPLY, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                                  Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
        send_request(make_request(QMR_ACT_MULTIPLY, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                                  32'sh0001_8000, -32'sh0002_0000, 32'sh0003_4000,
                                  -32'sh0000_8000));
        send_request(make_request(QMR_ACT_MULTIPLY, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO,
                                  Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO));
        send_request(make_request(QMR_ACT_MULTIPLY, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                  Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_request(make_request(QMR_ACT_MULTIPLY, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                  Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_request(make_request(QMR_ACT_MULTIPLY, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                  Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        // Rounding: an exact half rounds up, so +half gives one and -half gives zero.
        send_request(make_request(QMR_ACT_MULTIPLY, 32'sd1, Q_ZERO, Q_ZERO, Q_ZERO,
                                  32'sh0000_8000, Q_ZERO, Q_ZERO, Q_ZERO));
        send_request(make_request(QMR_ACT_MULTIPLY, -32'sd1, Q_ZERO, Q_ZERO, Q_ZERO,
                                  32'sh0000_8000, Q_ZERO, Q_ZERO, Q_ZERO));
        send_request(make_request(QMR_ACT_MULTIPLY, 32'sd1, Q_ZERO, Q_ZERO, Q_ZERO,
                                  32'sh0000_7FFF, Q_ZERO, Q_ZERO, Q_ZERO));
        send_request(make_request(QMR_ACT_MULTIPLY, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                                  -32'sd1, -32'sd1, -32'sd1, -32'sd1));
        send_request(make_request(QMR_ACT_MULTIPLY, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO,
                                  Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        // Rotations: identity with a non-zero real part on b that must be ignored.
        send_request(make_request(QMR_ACT_ROTATE, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                                  Q_MAX, Q_ONE, 32'sh0002_0000, 32'sh0003_0000));
        send_request(make_request(QMR_ACT_ROTATE, 32'sd46341, Q_ZERO, Q_ZERO, 32'sd46341,
                                  Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO));
        send_request(make_request(QMR_ACT_ROTATE, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO,
                                  Q_ZERO, 32'sd3, 32'sd5, -32'sd7));
        send_request(make_request(QMR_ACT_ROTATE, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                  Q_ZERO, Q_MAX, Q_MIN, Q_MAX));
        // A non-unit quaternion scales the vector by its squared norm.
        send_request(make_request(QMR_ACT_ROTATE, 32'sh0002_0000, Q_ZERO, Q_ZERO, Q_ZERO,
                                  Q_ZERO, 32'sh0064_0000, -32'sh0032_0000, 32'sd1));
        send_request(make_request(QMR_ACT_ROTATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                  Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_request(make_request(QMR_ACT_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                                  Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
        send_request(make_request(QMR_ACT_ROTATE, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO,
                                  Q_MIN, Q_ONE, Q_ONE, Q_ZERO));
        send_request(make_request(QMR_ACT_ROTATE, 32'sh0000_0100, 32'sh0000_0100,
                                  32'sh0000_0100, 32'sh0000_0100, Q_ZERO, Q_MAX, Q_MIN,
                                  Q_ONE));
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            // Change the idling pattern now and then, including spells with none at all.
            if (i % 200 == 0)
            begin
                case ($urandom_range(2))
                    0: send_gap_pct = 0;
                    1: send_gap_pct = 20;
                    default: send_gap_pct = 60;
                endcase
                case ($urandom_range(2))
                    0: sink_stall_pct = 0;
                    1: sink_stall_pct = 25;
                    default: sink_stall_pct = 60;
                endcase
            end
            send_request(rand_request(50));
        end
    endtask

    // Unit quaternions with vectors of moderate size, as in real use.
    task automatic test_unit_rotations(input int count);
        real     qw;
        real     qx;
        real     qy;
        real     qz;
        real     norm;
        qmr_in_t req;
        send_gap_pct   = 15;
        sink_stall_pct = 15;
        for (int i = 0; i < count; i++)
        begin
            qw   = (real'($urandom_range(2000)) - 1000.0) / 1000.0 + 0.001;
            qx   = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
            qy   = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
            qz   = (real'($urandom_range(2000)) - 1000.0) / 1000.0;
            norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
            req  = rand_request(80);
            req.a_w = comp_t'($rtoi(qw / norm * 65536.0));
            req.a_x = comp_t'($rtoi(qx / norm * 65536.0));
            req.a_y = comp_t'($rtoi(qy / norm * 65536.0));
            req.a_z = comp_t'($rtoi(qz / norm * 65536.0));
            req.b_x = comp_t'(int'($urandom_range(33554432)) - 16777216);
            req.b_y = comp_t'(int'($urandom_range(33554432)) - 16777216);
            req.b_z = comp_t'(int'($urandom_range(33554432)) - 16777216);
            send_request(req);
        end
    endtask

    // The sink holds off while requests keep coming, so the pipeline fills and stalls.
    task automatic test_back_pressure(input int count);
        send_gap_pct   = 0;
        sink_stall_pct = 10;
        sink_hold_req  = 1'b1;
        for (int i = 0; i < count; i++)
            send_request(rand_request(50));
    endtask

    task automatic test_full_rate(input int count);
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < count; i++)
            send_request(rand_request(50));
    endtask

    // ---------------------------------------------------------------- result sink

    initial
    begin : result_sink
        int stall;
        forever
        begin
            @(negedge clk);
            stall = pick_gap(sink_stall_pct);
            if (sink_hold_req)
            begin
                stall         = SINK_HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_comp(input string field, input comp_t got, input comp_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d (0x%08h) expected %0d (0x%08h)",
                                      field, got, got, want, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                next_result = pending_results.pop_front();
                check_comp("r_w", res.r_w, next_result.r_w);
                check_comp("r_x", res.r_x, next_result.r_x);
                check_comp("r_y", res.r_y, next_result.r_y);
                check_comp("r_z", res.r_z, next_result.r_z);
            end
            results_seen++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : test_sequence
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_random_mix(1400);
        test_unit_rotations(200);
        test_back_pressure(120);
        test_full_rate(100);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
